// File: src/bdc_pkg.sv
// shared constants and types for the button debounce click detector
package bdc_pkg;

   // register widths
   localparam int unsigned TimeWidth = 32;
   localparam int unsigned CfgWidth  = 16;

   // result codes
   localparam logic [1:0] EVT_NONE   = 2'd0;
   localparam logic [1:0] EVT_SINGLE = 2'd1;
   localparam logic [1:0] EVT_DOUBLE = 2'd2;

   // configuration register indexes
   localparam logic CSR_DEBOUNCE     = 1'b0;
   localparam logic CSR_DOUBLE_CLICK = 1'b1;

   // reset values of the configuration registers
   localparam logic [CfgWidth-1:0] DebounceReset    = CfgWidth'(25);
   localparam logic [CfgWidth-1:0] DoubleClickReset = CfgWidth'(350);

   typedef logic [TimeWidth-1:0] time_ms_type;
   typedef logic [CfgWidth-1:0]  cfg_word_type;
   typedef logic [1:0]           click_event_type;

endpackage

// File: src/bdc_req_if.sv
// input channel: raw button level and timestamp of one poll
interface bdc_req_if
   import bdc_pkg::*;
();
   logic        valid;
   logic        ready;
   logic        button_level;
   time_ms_type now_ms;

   modport source (output valid, output button_level, output now_ms, input ready);
   modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface

// File: src/bdc_rsp_if.sv
// result channel: click event of one poll
interface bdc_rsp_if
   import bdc_pkg::*;
();
   logic            valid;
   logic            ready;
   click_event_type click_event;

   modport source (output valid, output click_event, input ready);
   modport sink   (input valid, input click_event, output ready);
endinterface

// File: src/button_debounce_click_detector_unit.sv
// top level: debounce the button level and report single and double clicks
//
// Usage: every poll word on req_if carries the raw active-low pin level and a
// free-running millisecond timestamp. Each accepted poll yields exactly one
// word on rsp_if with click_event none, single or double, in poll order.
// The csr_ port writes debounce_ms (index 0) and double_click_ms (index 1);
// write it only while no poll is in flight.
// Path: an accepted poll waits in the input register, then the decision logic
// loads the result register.
// Throughput: one poll per cycle unless rsp_if stalls, set by the state
// update (two 32-bit wrapping subtracts and compares) between the registers.
// Reset: synchronous, active high; levels return to released, no click is
// pending, timers clear to 0 and the registers go to 25 and 350 ms.
// Stall: while rsp_if.ready is low the result holds; the input register
// still takes one more poll, then req_if.ready drops until the result leaves.
module button_debounce_click_detector_unit
   import bdc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   bdc_req_if.sink      req_if,
   bdc_rsp_if.source    rsp_if,
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  cfg_word_type csr_wr_data
);

   // configuration registers
   cfg_word_type debounce_ms_ff, debounce_ms_in;
   cfg_word_type double_click_ms_ff, double_click_ms_in;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_level_ff;
   time_ms_type s1_now_ff;

   // detector state
   logic        raw_level_ff, raw_level_in;
   logic        stable_level_ff, stable_level_in;
   time_ms_type change_time_ff, change_time_in;
   logic        pending_ff, pending_in;
   time_ms_type first_press_ff, first_press_in;

   // result register
   logic            out_valid_ff, out_valid_in;
   click_event_type out_event_ff, out_event_in;

   // decision logic signals
   logic            out_free;
   logic            s1_adv;
   logic            level_changed;
   time_ms_type     debounce_diff;
   time_ms_type     press_diff;
   logic            settled;
   logic            new_press;
   logic            in_window;
   click_event_type evt;

   // handshake
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_if.ready = !s1_valid_ff || out_free;
   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.click_event = out_event_ff;

   // configuration writes
   always_comb begin
      debounce_ms_in     = debounce_ms_ff;
      double_click_ms_in = double_click_ms_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE:     debounce_ms_in     = csr_wr_data;
            CSR_DOUBLE_CLICK: double_click_ms_in = csr_wr_data;
            default:          debounce_ms_in     = debounce_ms_ff;
         endcase
      end
   end

   // debounce and press detection
   assign level_changed = s1_level_ff != raw_level_ff;
   assign debounce_diff = level_changed ? '0 : (s1_now_ff - change_time_ff);
   assign settled       = debounce_diff > time_ms_type'(debounce_ms_ff);
   assign new_press     = settled && (s1_level_ff != stable_level_ff) && !s1_level_ff;
   assign press_diff    = s1_now_ff - first_press_ff;
   assign in_window     = press_diff <= time_ms_type'(double_click_ms_ff);

   // click state update and event choice
   always_comb begin
      raw_level_in    = raw_level_ff;
      stable_level_in = stable_level_ff;
      change_time_in  = change_time_ff;
      pending_in      = pending_ff;
      first_press_in  = first_press_ff;
      evt             = EVT_NONE;
      if (s1_adv) begin
         if (level_changed) begin
            raw_level_in   = s1_level_ff;
            change_time_in = s1_now_ff;
         end
         if (settled) begin
            stable_level_in = s1_level_ff;
         end
         priority if (new_press && pending_ff && in_window) begin
            pending_in = 1'b0;
            evt        = EVT_DOUBLE;
         end else if (new_press) begin
            pending_in     = 1'b1;
            first_press_in = s1_now_ff;
         end else if (pending_ff && !in_window) begin
            pending_in = 1'b0;
            evt        = EVT_SINGLE;
         end
      end
   end

   // pipeline next values
   always_comb begin
      s1_valid_in  = s1_adv ? 1'b0 : s1_valid_ff;
      if (req_if.valid && req_if.ready) begin
         s1_valid_in = 1'b1;
      end
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_event_in = out_event_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
         out_event_in = evt;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff     <= DebounceReset;
         double_click_ms_ff <= DoubleClickReset;
         s1_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         raw_level_ff       <= 1'b1;
         stable_level_ff    <= 1'b1;
         change_time_ff     <= '0;
         pending_ff         <= 1'b0;
         first_press_ff     <= '0;
      end else begin
         debounce_ms_ff     <= debounce_ms_in;
         double_click_ms_ff <= double_click_ms_in;
         s1_valid_ff        <= s1_valid_in;
         out_valid_ff       <= out_valid_in;
         raw_level_ff       <= raw_level_in;
         stable_level_ff    <= stable_level_in;
         change_time_ff     <= change_time_in;
         pending_ff         <= pending_in;
         first_press_ff     <= first_press_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_event_ff <= out_event_in;
      if (req_if.valid && req_if.ready) begin
         s1_level_ff <= req_if.button_level;
         s1_now_ff   <= req_if.now_ms;
      end
   end

`ifndef ASSERT_OFF
   // a double click always clears the pending single click
   a_double_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && evt == EVT_DOUBLE) |=> !pending_ff)
      else $error("pending click survived a double click");

   // a single click is only reported from a pending click
   a_single_needs_pending: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && evt == EVT_SINGLE) |-> pending_ff)
      else $error("single click without a pending press");

   // a stalled result keeps the poll waiting in the input register
   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_if.ready) |=> s1_valid_ff)
      else $error("poll lost while the result was stalled");

   // input side is only blocked when the input register is occupied
   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (s1_valid_ff && out_valid_ff))
      else $error("input blocked without a reason");

   // a newly armed click starts its window at the poll time
   a_arm_time: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && new_press && !pending_ff) |=> (pending_ff && first_press_ff == $past(s1_now_ff)))
      else $error("pending click armed with a wrong time");
`endif

endmodule
